// ===== src/ga_pkg.sv =====
// ----------------------------------------------------------------------------
// ga_pkg
// Shared types, constants and width helpers for the generalized anisotropy
// core.
// ----------------------------------------------------------------------------
package ga_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int ANIS_W          = 17;
  localparam int STATUS_W        = 2;
  localparam int MAX_SAMPLES_DEF = 128;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;
  // floor(num * 2^32 / den) with num <= den fits in 33 bits
  localparam int RATIO_W         = 33;
  localparam int ROOT_STEPS      = (RATIO_W + 1) / 2;
  localparam logic [ANIS_W-1:0] ANIS_MAX = ANIS_W'(65536);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FEW      = 2'd1,
    STATUS_ZERO     = 2'd2,
    STATUS_TOO_MANY = 2'd3
  } status_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } in_t;

  typedef struct packed {
    logic [ANIS_W-1:0] anisotropy;
    status_e           status;
  } out_t;

  function automatic int sb_eff(input int sample_bits);
    return (sample_bits < SAMPLE_W) ? sample_bits : SAMPLE_W;
  endfunction

  function automatic int cnt_width(input int max_samples);
    return $clog2(max_samples + 1);
  endfunction

  function automatic int s1_width(input int sample_bits, input int max_samples);
    return sb_eff(sample_bits) + cnt_width(max_samples);
  endfunction

  function automatic int s2_width(input int sample_bits, input int max_samples);
    return 2 * sb_eff(sample_bits) + cnt_width(max_samples);
  endfunction

endpackage

// ===== src/ga_queue.sv =====
// ----------------------------------------------------------------------------
// ga_queue
// Short flip-flop queue carrying finished voxel sums from front to back end.
// ----------------------------------------------------------------------------
module ga_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o      = (count_q == CNT_W'(DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ptr_next(wr_ptr_q);
    end
    if (pop_i) begin
      rd_ptr_d = ptr_next(rd_ptr_q);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/ga_front.sv =====
// ----------------------------------------------------------------------------
// ga_front
// Accumulates count, sum and sum of squares, one sample per cycle while the
// queue is not full, and hands the voxel totals to the queue on the last sample.
// ----------------------------------------------------------------------------
module ga_front import ga_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_stall_o,
  input  in_t                                          in_data_i,
  input  logic                                         full_i,
  output logic                                         push_o,
  output logic                                         job_ovf_o,
  output logic [cnt_width(MAX_SAMPLES)-1:0]            job_cnt_o,
  output logic [s1_width(SAMPLE_BITS, MAX_SAMPLES)-1:0] job_s1_o,
  output logic [s2_width(SAMPLE_BITS, MAX_SAMPLES)-1:0] job_s2_o
);

  localparam int SB   = sb_eff(SAMPLE_BITS);
  localparam int CNT_W = cnt_width(MAX_SAMPLES);
  localparam int S1_W = s1_width(SAMPLE_BITS, MAX_SAMPLES);
  localparam int S2_W = s2_width(SAMPLE_BITS, MAX_SAMPLES);

  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_nx;
  logic [S1_W-1:0]  sum_q, sum_d, sum_nx;
  logic [S2_W-1:0]  sq_q, sq_d, sq_nx;
  logic             ovf_q, ovf_d, ovf_nx;
  logic [SB-1:0]    smp;
  logic [2*SB-1:0]  smp_sq;
  logic             accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign smp        = in_data_i.sample[SB-1:0];
  assign smp_sq     = (2*SB)'(smp) * (2*SB)'(smp);

  always_comb begin
    cnt_nx = cnt_q;
    sum_nx = sum_q;
    sq_nx  = sq_q;
    ovf_nx = ovf_q;
    if (cnt_q >= CNT_W'(MAX_SAMPLES)) begin
      ovf_nx = 1'b1;
    end else begin
      cnt_nx = cnt_q + CNT_W'(1);
      sum_nx = sum_q + S1_W'(smp);
      sq_nx  = sq_q + S2_W'(smp_sq);
    end
  end

  assign push_o    = accept && in_data_i.last;
  assign job_ovf_o = ovf_nx;
  assign job_cnt_o = cnt_nx;
  assign job_s1_o  = sum_nx;
  assign job_s2_o  = sq_nx;

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    sq_d  = sq_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (in_data_i.last) begin
        cnt_d = '0;
        sum_d = '0;
        sq_d  = '0;
        ovf_d = 1'b0;
      end else begin
        cnt_d = cnt_nx;
        sum_d = sum_nx;
        sq_d  = sq_nx;
        ovf_d = ovf_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
      sq_q  <= sq_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

// ===== src/ga_back.sv =====
// ----------------------------------------------------------------------------
// ga_back
// Sequencer: shift-add products, restoring division and bit-pair square root
// for one voxel (status-only voxels skip them), then the result register.
// ----------------------------------------------------------------------------
module ga_back import ga_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         pop_valid_i,
  output logic                                         pop_o,
  input  logic                                         job_ovf_i,
  input  logic [cnt_width(MAX_SAMPLES)-1:0]            job_cnt_i,
  input  logic [s1_width(SAMPLE_BITS, MAX_SAMPLES)-1:0] job_s1_i,
  input  logic [s2_width(SAMPLE_BITS, MAX_SAMPLES)-1:0] job_s2_i,
  output logic                                         out_valid_o,
  input  logic                                         out_stall_i,
  output out_t                                         out_data_o
);

  localparam int CNT_W  = cnt_width(MAX_SAMPLES);
  localparam int S1_W   = s1_width(SAMPLE_BITS, MAX_SAMPLES);
  localparam int P_W    = 2 * S1_W;
  localparam int R_W    = P_W + 1;
  localparam int RES_W  = RATIO_W + 1;
  localparam int MAX_ST = (S1_W > RATIO_W) ? S1_W : RATIO_W;
  localparam int STEP_W = $clog2(MAX_ST + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_ROOT = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic               res_pend_q, res_pend_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [CNT_W-1:0]   mul_n_q, mul_n_d, mul_d_q, mul_d_d;
  logic [S1_W-1:0]    mul_s_q, mul_s_d;
  logic [P_W-1:0]     sh_s2_q, sh_s2_d, sh_s1_q, sh_s1_d;
  logic [P_W-1:0]     acc_n_q, acc_n_d, acc_d_q, acc_d_d, acc_s_q, acc_s_d;
  logic [R_W-1:0]     rem_q, rem_d;
  logic [RATIO_W-1:0] quo_q, quo_d, bit_q, bit_d;
  logic [RES_W-1:0]   root_q, root_d;
  logic [ANIS_W-1:0]  anis_q, anis_d;
  status_e            status_q, status_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic               div_ge;
  logic [R_W-1:0]     div_diff;
  logic [RES_W-1:0]   root_trial, root_nx;
  logic               root_ge;
  logic               load_out;

  assign load_out    = res_pend_q && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign div_ge     = (rem_q >= {1'b0, acc_d_q});
  assign div_diff   = div_ge ? (rem_q - {1'b0, acc_d_q}) : rem_q;
  assign root_trial = root_q + RES_W'(bit_q);
  assign root_ge    = ({1'b0, quo_q} >= root_trial);
  assign root_nx    = root_ge ? ((root_q >> 1) + RES_W'(bit_q)) : (root_q >> 1);

  always_comb begin
    state_d    = state_q;
    res_pend_d = res_pend_q;
    step_d     = step_q;
    mul_n_d    = mul_n_q;
    mul_d_d    = mul_d_q;
    mul_s_d    = mul_s_q;
    sh_s2_d    = sh_s2_q;
    sh_s1_d    = sh_s1_q;
    acc_n_d    = acc_n_q;
    acc_d_d    = acc_d_q;
    acc_s_d    = acc_s_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    bit_d      = bit_q;
    root_d     = root_q;
    anis_d     = anis_q;
    status_d   = status_q;
    pop_o      = 1'b0;
    if (load_out) begin
      res_pend_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (pop_valid_i && !res_pend_q) begin
          pop_o  = 1'b1;
          anis_d = '0;
          if (job_ovf_i) begin
            status_d   = STATUS_TOO_MANY;
            res_pend_d = 1'b1;
          end else if (job_cnt_i < CNT_W'(2)) begin
            status_d   = STATUS_FEW;
            res_pend_d = 1'b1;
          end else if (job_s2_i == '0) begin
            status_d   = STATUS_ZERO;
            res_pend_d = 1'b1;
          end else begin
            status_d = STATUS_OK;
            mul_n_d  = job_cnt_i;
            mul_d_d  = job_cnt_i - CNT_W'(1);
            mul_s_d  = job_s1_i;
            sh_s2_d  = P_W'(job_s2_i);
            sh_s1_d  = P_W'(job_s1_i);
            acc_n_d  = '0;
            acc_d_d  = '0;
            acc_s_d  = '0;
            step_d   = '0;
            state_d  = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mul_n_q[0]) acc_n_d = acc_n_q + sh_s2_q;
        if (mul_d_q[0]) acc_d_d = acc_d_q + sh_s2_q;
        if (mul_s_q[0]) acc_s_d = acc_s_q + sh_s1_q;
        mul_n_d = mul_n_q >> 1;
        mul_d_d = mul_d_q >> 1;
        mul_s_d = mul_s_q >> 1;
        sh_s2_d = sh_s2_q << 1;
        sh_s1_d = sh_s1_q << 1;
        step_d  = step_q + STEP_W'(1);
        if (step_q == STEP_W'(S1_W - 1)) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        rem_d   = {1'b0, acc_n_q - acc_s_q};
        quo_d   = '0;
        step_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d  = div_diff << 1;
        quo_d  = {quo_q[RATIO_W-2:0], div_ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(RATIO_W - 1)) begin
          root_d  = '0;
          bit_d   = RATIO_W'(1) << (RATIO_W - 1);
          step_d  = '0;
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root_ge) begin
          quo_d = quo_q - root_trial[RATIO_W-1:0];
        end
        root_d = root_nx;
        bit_d  = bit_q >> 2;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
          anis_d     = (root_nx > RES_W'(ANIS_MAX)) ? ANIS_MAX : root_nx[ANIS_W-1:0];
          res_pend_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d      = 1'b1;
      out_d.anisotropy = anis_q;
      out_d.status     = status_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_pend_q  <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_pend_q  <= res_pend_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_n_q  <= mul_n_d;
    mul_d_q  <= mul_d_d;
    mul_s_q  <= mul_s_d;
    sh_s2_q  <= sh_s2_d;
    sh_s1_q  <= sh_s1_d;
    acc_n_q  <= acc_n_d;
    acc_d_q  <= acc_d_d;
    acc_s_q  <= acc_s_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    bit_q    <= bit_d;
    root_q   <= root_d;
    anis_q   <= anis_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

endmodule

// ===== src/generalized_anisotropy_core.sv =====
// ----------------------------------------------------------------------------
// generalized_anisotropy_core
// Streams diffusion samples of a voxel and returns its generalized anisotropy
// (65536 = 1.0) and a status on the sample marked last.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle into the count, sum and sum-of-squares
// accumulators; the input stalls only while the two-entry voxel queue is
// full. Each voxel's result is then computed in the back end by the
// bit-serial products, the 33-step restoring division and the 17-step root;
// status-only results (too many, fewer than two, zero energy) skip them.
module generalized_anisotropy_core import ga_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int CNT_W = cnt_width(MAX_SAMPLES);
  localparam int S1_W  = s1_width(SAMPLE_BITS, MAX_SAMPLES);
  localparam int S2_W  = s2_width(SAMPLE_BITS, MAX_SAMPLES);
  localparam int JOB_W = 1 + CNT_W + S1_W + S2_W;

  logic             push, full, pop, pop_valid;
  logic             f_ovf, b_ovf;
  logic [CNT_W-1:0] f_cnt, b_cnt;
  logic [S1_W-1:0]  f_s1, b_s1;
  logic [S2_W-1:0]  f_s2, b_s2;
  logic [JOB_W-1:0] job_in, job_out;

  ga_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .job_ovf_o  (f_ovf),
    .job_cnt_o  (f_cnt),
    .job_s1_o   (f_s1),
    .job_s2_o   (f_s2)
  );

  assign job_in = {f_ovf, f_cnt, f_s1, f_s2};

  ga_queue #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job_in),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (job_out)
  );

  assign {b_ovf, b_cnt, b_s1, b_s2} = job_out;

  ga_back #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .job_ovf_i   (b_ovf),
    .job_cnt_i   (b_cnt),
    .job_s1_i    (b_s1),
    .job_s2_i    (b_s2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for generalized_anisotropy_core. Voxels of samples are
// streamed in with random gaps, results are taken with random stalls, and
// each result is compared against a bit-exact integer model of the
// anisotropy and status held in a small scoreboard.
// ----------------------------------------------------------------------------
module tb;
  import ga_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int RANDOM_ITEMS = 250;
  localparam int DRAIN_CYCLES = 120;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_FLAT,
    FILL_EXTREME,
    FILL_SPARSE,
    FILL_NEAR
  } fill_e;

  class anisotropy_scoreboard;
    int unsigned     n_held;
    longint unsigned sum_s;
    longint unsigned sum_sq;
    bit              overflowed;
    out_t            expected_q[$];
    int              errors;

    function new();
      clear_voxel();
      errors = 0;
    endfunction

    function void clear_voxel();
      n_held     = 0;
      sum_s      = 0;
      sum_sq     = 0;
      overflowed = 1'b0;
    endfunction

    // floor(sqrt((n*S2 - S1^2) * 2^32 / ((n-1)*S2))), clamped to 1.0
    function logic [ANIS_W-1:0] voxel_anisotropy();
      bit [127:0] num;
      bit [127:0] den;
      bit [127:0] ratio;
      bit [33:0]  x;
      bit [17:0]  root;
      bit [17:0]  trial;
      num   = 128'(n_held) * 128'(sum_sq) - 128'(sum_s) * 128'(sum_s);
      den   = 128'(n_held - 1) * 128'(sum_sq);
      ratio = (num << 32) / den;
      x     = ratio[33:0];
      root  = '0;
      for (int b = 16; b >= 0; b--) begin
        trial = root | (18'd1 << b);
        if (64'(trial) * 64'(trial) <= 64'(x)) root = trial;
      end
      if (root > 18'd65536) root = 18'd65536;
      return ANIS_W'(root);
    endfunction

    function void note_sample(in_t d);
      longint unsigned s;
      out_t            want;
      s = 64'(d.sample) & ((64'd1 << SAMPLE_BITS_DEF) - 64'd1);
      if (n_held >= MAX_SAMPLES_DEF) begin
        overflowed = 1'b1;
      end else begin
        n_held++;
        sum_s  += s;
        sum_sq += s * s;
      end
      if (!d.last) return;
      want.anisotropy = '0;
      if (overflowed) want.status = STATUS_TOO_MANY;
      else if (n_held < 2) want.status = STATUS_FEW;
      else if (sum_sq == 0) want.status = STATUS_ZERO;
      else begin
        want.status     = STATUS_OK;
        want.anisotropy = voxel_anisotropy();
      end
      expected_q.push_back(want);
      clear_voxel();
    endfunction

    task report(string what);
      $display("tb: mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected transaction, anisotropy %0d status %0d",
                         got.anisotropy, got.status));
        return;
      end
      want = expected_q.pop_front();
      if (got.anisotropy !== want.anisotropy)
        report($sformatf("anisotropy %0d, expected %0d", got.anisotropy, want.anisotropy));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  anisotropy_scoreboard sb;
  int in_run  = 0;
  int out_run = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  generalized_anisotropy_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  always #5 clk_i = ~clk_i;

  // occasional runs of back-to-back transactions between random waits
  function automatic int draw_wait(inout int run);
    if (run == 0 && $urandom_range(0, 39) == 0) run = $urandom_range(8, 40);
    if (run > 0) begin
      run--;
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [SAMPLE_W-1:0] fill_value(fill_e kind, logic [SAMPLE_W-1:0] base);
    case (kind)
      FILL_RANDOM:  return SAMPLE_W'($urandom_range(0, 65535));
      FILL_ZERO:    return '0;
      FILL_FLAT:    return base;
      FILL_EXTREME: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      FILL_SPARSE:  return ($urandom_range(0, 5) == 0) ? SAMPLE_W'($urandom_range(1, 65535)) : '0;
      FILL_NEAR:    return base ^ SAMPLE_W'($urandom_range(0, 7));
      default:      return '0;
    endcase
  endfunction

  task automatic send_sample(logic [SAMPLE_W-1:0] s, logic last);
    int  gap;
    in_t d;
    gap    = draw_wait(in_run);
    d.sample = s;
    d.last   = last;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(d);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_voxel(int len, fill_e kind);
    logic [SAMPLE_W-1:0] base;
    base = SAMPLE_W'($urandom);
    for (int i = 0; i < len; i++) send_sample(fill_value(kind, base), i == len - 1);
  endtask

  task automatic send_random_voxel();
    int    r;
    int    len;
    fill_e kind;
    r = $urandom_range(0, 99);
    if (r < 4) len = 1;
    else if (r < 7) len = $urandom_range(MAX_SAMPLES_DEF - 3, MAX_SAMPLES_DEF + 3);
    else len = $urandom_range(2, 12);
    case ($urandom_range(0, 9))
      4:       kind = FILL_NEAR;
      5:       kind = FILL_FLAT;
      6:       kind = FILL_EXTREME;
      7:       kind = FILL_SPARSE;
      8:       kind = FILL_ZERO;
      default: kind = FILL_RANDOM;
    endcase
    send_voxel(len, kind);
  endtask

  // stimulus
  initial begin
    int start_items;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    sb = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_sample(16'hFFFF, 1'b1);        // single sample
    send_sample(16'h0000, 1'b1);        // single zero: too few wins
    send_sample(16'h0000, 1'b0);        // zero energy
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0000, 1'b0);        // full scale anisotropy
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 1'b0);        // flat at full scale
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_voxel(MAX_SAMPLES_DEF, FILL_RANDOM);      // count at its limit
    send_voxel(MAX_SAMPLES_DEF + 1, FILL_RANDOM);  // one too many
    send_voxel(MAX_SAMPLES_DEF + 2, FILL_ZERO);    // too many beats zero energy

    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) send_random_voxel();
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("results still pending at end of run");
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      n = draw_wait(out_run);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
src/ga_pkg.sv
src/ga_queue.sv
src/ga_front.sv
src/ga_back.sv
src/generalized_anisotropy_core.sv
sim/tb.sv
